// ===== src/msc_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and speed range tables for the speed table check
package msc_pkg;

    localparam int AXIS_W      = 8;
    localparam int VEL_W       = 32;
    localparam int RATE_W      = 40;
    localparam int STATUS_W    = 3;
    localparam int START_W     = 22;
    localparam int TOP_W       = 23;
    localparam int UNITS_W     = 14;
    localparam int RANGE_COUNT = 15;
    localparam int RANGE_W     = 4;
    localparam int Q_W         = 6;
    localparam int RECIP_W     = 33;
    localparam int RECIP_SHIFT = 32;
    localparam int RAMP_SCALE  = 100;
    localparam int SCALE_W     = 7;

    localparam logic [TOP_W-1:0]   TOP_MAX   = 23'd5000000;
    localparam logic [START_W-1:0] START_MAX = 22'd2500000;
    localparam logic [UNITS_W-1:0] UNITS_MAX = 14'd10000;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_BAD_AXIS = 3'd1,
        ST_RANGE    = 3'd2,
        ST_START    = 3'd3,
        ST_RAMP     = 3'd4
    } status_t;

    typedef logic [RANGE_W-1:0] range_idx_t;

    // sideband that rides along with an item through the back stages
    typedef struct packed {
        status_t             status;
        logic [START_W-1:0]  start;
        logic [TOP_W-1:0]    top;
        range_idx_t          range;
    } ctx_t;

    // upper bound of each speed range, steps/s
    function automatic logic [TOP_W-1:0] range_upper(input range_idx_t idx);
        logic [TOP_W-1:0] v;
        unique case (idx)
            4'd0:    v = 23'd20;
            4'd1:    v = 23'd250;
            4'd2:    v = 23'd500;
            4'd3:    v = 23'd1000;
            4'd4:    v = 23'd2500;
            4'd5:    v = 23'd5000;
            4'd6:    v = 23'd10000;
            4'd7:    v = 23'd25000;
            4'd8:    v = 23'd50000;
            4'd9:    v = 23'd100000;
            4'd10:   v = 23'd250000;
            4'd11:   v = 23'd500000;
            4'd12:   v = 23'd1000000;
            4'd13:   v = 23'd2000000;
            default: v = 23'd5000000;
        endcase
        return v;
    endfunction

    // speed quantum of each range
    function automatic logic [Q_W-1:0] range_quantum(input range_idx_t idx);
        logic [Q_W-1:0] v;
        unique case (idx)
            4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5: v = 6'd1;
            4'd6:    v = 6'd2;
            4'd7:    v = 6'd5;
            4'd8:    v = 6'd10;
            4'd9:    v = 6'd20;
            default: v = 6'd50;
        endcase
        return v;
    endfunction

    // ceil(2^32 / quantum), exact floor division for 23 bit dividends
    function automatic logic [RECIP_W-1:0] range_recip(input range_idx_t idx);
        logic [RECIP_W-1:0] v;
        unique case (idx)
            4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5: v = 33'h1_0000_0000;
            4'd6:    v = 33'd2147483648;
            4'd7:    v = 33'd858993460;
            4'd8:    v = 33'd429496730;
            4'd9:    v = 33'd214748365;
            default: v = 33'd85899346;
        endcase
        return v;
    endfunction

    // lower ramp limit of each range in 10 ms units
    function automatic logic [UNITS_W-1:0] range_min_units(input range_idx_t idx);
        logic [UNITS_W-1:0] v;
        unique case (idx)
            4'd12:   v = 14'd2;
            4'd13:   v = 14'd4;
            4'd14:   v = 14'd10;
            default: v = 14'd1;
        endcase
        return v;
    endfunction

    // upper ramp limit of each range in 10 ms units
    function automatic logic [UNITS_W-1:0] range_max_units(input range_idx_t idx);
        logic [UNITS_W-1:0] v;
        unique case (idx)
            4'd0:    v = 14'd10;
            4'd1:    v = 14'd100;
            4'd12:   v = 14'd2000;
            4'd13:   v = 14'd4000;
            4'd14:   v = 14'd10000;
            default: v = 14'd1000;
        endcase
        return v;
    endfunction

endpackage

// ===== src/msc_front.sv =====
`timescale 1ns / 1ps
// first stage: input limit checks, range pick and pre-rounding of the velocities
module msc_front #(
    parameter int FRACTION_BITS = 8,
    parameter int AXIS_LIMIT    = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [msc_pkg::AXIS_W-1:0]    axis_number,
    input  logic [msc_pkg::VEL_W-1:0]     start_velocity,
    input  logic [msc_pkg::VEL_W-1:0]     top_velocity,
    input  logic [msc_pkg::RATE_W-1:0]    ramp_rate,
    output logic                          out_valid,
    input  logic                          out_ready,
    output msc_pkg::status_t              out_status,
    output msc_pkg::range_idx_t           out_range,
    output logic [msc_pkg::TOP_W-1:0]     out_top_pre,
    output logic [msc_pkg::START_W-1:0]   out_start,
    output logic [msc_pkg::RATE_W-1:0]    out_rate
);

    localparam int CW = ((msc_pkg::VEL_W > msc_pkg::TOP_W + FRACTION_BITS) ?
                         msc_pkg::VEL_W : msc_pkg::TOP_W + FRACTION_BITS) + 1;
    localparam int SW = ((msc_pkg::VEL_W + 1 > msc_pkg::Q_W + FRACTION_BITS) ?
                         msc_pkg::VEL_W + 1 : msc_pkg::Q_W + FRACTION_BITS) + 1;

    logic                        valid_reg;
    msc_pkg::status_t            status_reg, status_next;
    msc_pkg::range_idx_t         range_reg, range_next;
    logic [msc_pkg::TOP_W-1:0]   top_pre_reg;
    logic [msc_pkg::START_W-1:0] start_reg;
    logic [msc_pkg::RATE_W-1:0]  rate_reg;

    logic [CW-1:0]               tv_w, sv_w, one_w;
    logic                        axis_bad, range_bad;
    logic [msc_pkg::Q_W-1:0]     quantum;
    logic [SW-1:0]               t_sum, t_shift, s_sum, s_shift;
    logic                        load;

    assign load     = !valid_reg || out_ready;
    assign in_ready = load;

    // limit checks and first matching range
    always_comb begin
        tv_w  = CW'(top_velocity);
        sv_w  = CW'(start_velocity);
        one_w = CW'(1) << FRACTION_BITS;
        axis_bad = (axis_number == '0) ||
                   (axis_number > msc_pkg::AXIS_W'(AXIS_LIMIT));
        range_bad = (sv_w < one_w) || (tv_w < (one_w << 1)) ||
                    (tv_w > (CW'(msc_pkg::TOP_MAX) << FRACTION_BITS)) ||
                    (sv_w > (CW'(msc_pkg::START_MAX) << FRACTION_BITS)) ||
                    (ramp_rate == '0);
        range_next = msc_pkg::range_idx_t'(msc_pkg::RANGE_COUNT - 1);
        for (int i = msc_pkg::RANGE_COUNT - 1; i >= 0; i--) begin
            if (tv_w <= (CW'(msc_pkg::range_upper(msc_pkg::range_idx_t'(i)))
                         << FRACTION_BITS)) begin
                range_next = msc_pkg::range_idx_t'(i);
            end
        end
        if (axis_bad) begin
            status_next = msc_pkg::ST_BAD_AXIS;
        end else if (range_bad) begin
            status_next = msc_pkg::ST_RANGE;
        end else begin
            status_next = msc_pkg::ST_OK;
        end
    end

    // half-up rounding offsets, dropping the fraction and the doubling bit
    always_comb begin
        quantum = msc_pkg::range_quantum(range_next);
        t_sum   = (SW'(top_velocity) << 1) + (SW'(quantum) << FRACTION_BITS);
        t_shift = t_sum >> (FRACTION_BITS + 1);
        s_sum   = (SW'(start_velocity) << 1) + (SW'(1) << FRACTION_BITS);
        s_shift = s_sum >> (FRACTION_BITS + 1);
    end

    // valid bit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= in_valid;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (load) begin
            status_reg  <= status_next;
            range_reg   <= range_next;
            top_pre_reg <= t_shift[msc_pkg::TOP_W-1:0];
            start_reg   <= s_shift[msc_pkg::START_W-1:0];
            rate_reg    <= ramp_rate;
        end
    end

    assign out_valid   = valid_reg;
    assign out_status  = status_reg;
    assign out_range   = range_reg;
    assign out_top_pre = top_pre_reg;
    assign out_start   = start_reg;
    assign out_rate    = rate_reg;

endmodule

// ===== src/msc_quant.sv =====
`timescale 1ns / 1ps
// two stages: top speed snapped to the range quantum, then start against top checks
module msc_quant (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  msc_pkg::status_t              in_status,
    input  msc_pkg::range_idx_t           in_range,
    input  logic [msc_pkg::TOP_W-1:0]     in_top_pre,
    input  logic [msc_pkg::START_W-1:0]   in_start,
    input  logic [msc_pkg::RATE_W-1:0]    in_rate,
    output logic                          out_valid,
    input  logic                          out_ready,
    output msc_pkg::ctx_t                 out_ctx,
    output logic [msc_pkg::RATE_W-1:0]    out_rate
);

    localparam int PW = msc_pkg::TOP_W + msc_pkg::RECIP_W;
    localparam int TW = msc_pkg::TOP_W + msc_pkg::Q_W;

    // stage a: quotient by the quantum through the reciprocal
    logic                        a_valid_reg;
    msc_pkg::status_t            a_status_reg;
    msc_pkg::range_idx_t         a_range_reg;
    logic [msc_pkg::TOP_W-1:0]   a_qt_reg;
    logic [msc_pkg::START_W-1:0] a_start_reg;
    logic [msc_pkg::RATE_W-1:0]  a_rate_reg;
    logic [PW-1:0]               a_prod;
    logic                        a_load;

    // stage b: snapped top speed and checks
    logic                        b_valid_reg;
    msc_pkg::ctx_t               b_ctx_reg, b_ctx_next;
    logic [msc_pkg::RATE_W-1:0]  b_rate_reg;
    logic [TW-1:0]               b_top;
    logic                        b_bad;
    logic                        b_load;

    assign b_load   = !b_valid_reg || out_ready;
    assign a_load   = !a_valid_reg || b_load;
    assign in_ready = a_load;

    assign a_prod = PW'(in_top_pre) * PW'(msc_pkg::range_recip(in_range));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            if (a_load) begin
                a_valid_reg <= in_valid;
            end
            if (b_load) begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (a_load) begin
            a_status_reg <= in_status;
            a_range_reg  <= in_range;
            a_qt_reg     <= a_prod[msc_pkg::RECIP_SHIFT +: msc_pkg::TOP_W];
            a_start_reg  <= in_start;
            a_rate_reg   <= in_rate;
        end
    end

    // snapped top and the start over half top check
    always_comb begin
        b_top = TW'(a_qt_reg) * TW'(msc_pkg::range_quantum(a_range_reg));
        b_bad = (b_top < TW'(2)) || (b_top > TW'(msc_pkg::TOP_MAX)) ||
                (a_start_reg == '0) || (a_start_reg > msc_pkg::START_MAX) ||
                ((TW'(a_start_reg) << 1) > b_top);
        b_ctx_next.status = a_status_reg;
        if (a_status_reg == msc_pkg::ST_OK && b_bad) begin
            b_ctx_next.status = msc_pkg::ST_START;
        end
        b_ctx_next.start = a_start_reg;
        b_ctx_next.top   = b_top[msc_pkg::TOP_W-1:0];
        b_ctx_next.range = a_range_reg;
    end

    always_ff @(posedge aclk) begin
        if (b_load) begin
            b_ctx_reg  <= b_ctx_next;
            b_rate_reg <= a_rate_reg;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_ctx   = b_ctx_reg;
    assign out_rate  = b_rate_reg;

endmodule

// ===== src/msc_div.sv =====
`timescale 1ns / 1ps
// pipelined restoring divider, two quotient bits per stage, with overflow flag
module msc_div #(
    parameter int NUM_W = 49
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [NUM_W-1:0]              in_num,
    input  logic [msc_pkg::RATE_W:0]      in_den,
    input  msc_pkg::ctx_t                 in_ctx,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [msc_pkg::UNITS_W-1:0]   out_quot,
    output logic                          out_ovf,
    output msc_pkg::ctx_t                 out_ctx
);

    localparam int QW     = msc_pkg::UNITS_W;
    localparam int DEN_W  = msc_pkg::RATE_W + 1;
    localparam int RW     = (NUM_W > DEN_W + QW) ? NUM_W : DEN_W + QW;
    localparam int STEPS  = 2;
    localparam int STAGES = (QW + STEPS - 1) / STEPS;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] load;
    logic [RW-1:0]     rem_reg  [STAGES];
    logic [QW-1:0]     quot_reg [STAGES];
    logic              ovf_reg  [STAGES];
    logic [DEN_W-1:0]  den_reg  [STAGES];
    msc_pkg::ctx_t     ctx_reg  [STAGES];

    assign in_ready = load[0];

    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        logic              v_in;
        logic [RW-1:0]     rem_in, rem_next;
        logic [QW-1:0]     quot_in, quot_next;
        logic              ovf_in, ovf_next;
        logic [DEN_W-1:0]  den_in;
        msc_pkg::ctx_t     ctx_in;

        if (s == 0) begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = RW'(in_num);
            assign quot_in = '0;
            assign ovf_in  = 1'b0;
            assign den_in  = in_den;
            assign ctx_in  = in_ctx;
        end else begin : g_rest
            assign v_in    = valid_reg[s-1];
            assign rem_in  = rem_reg[s-1];
            assign quot_in = quot_reg[s-1];
            assign ovf_in  = ovf_reg[s-1];
            assign den_in  = den_reg[s-1];
            assign ctx_in  = ctx_reg[s-1];
        end

        if (s == STAGES - 1) begin : g_last_ready
            assign load[s] = !valid_reg[s] || out_ready;
        end else begin : g_mid_ready
            assign load[s] = !valid_reg[s] || load[s+1];
        end

        // compare and subtract for this stage's quotient bits
        always_comb begin
            int b;
            rem_next  = rem_in;
            quot_next = quot_in;
            ovf_next  = ovf_in;
            if (s == 0) begin
                ovf_next = (rem_in >= (RW'(den_in) << QW));
            end
            for (int j = 0; j < STEPS; j++) begin
                b = QW - 1 - (s * STEPS + j);
                if (b >= 0) begin
                    if (rem_next >= (RW'(den_in) << b)) begin
                        rem_next = rem_next - (RW'(den_in) << b);
                        quot_next[b[$clog2(QW)-1:0]] = 1'b1;
                    end
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[s] <= 1'b0;
            end else if (load[s]) begin
                valid_reg[s] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (load[s]) begin
                rem_reg[s]  <= rem_next;
                quot_reg[s] <= quot_next;
                ovf_reg[s]  <= ovf_next;
                den_reg[s]  <= den_in;
                ctx_reg[s]  <= ctx_in;
            end
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign out_quot  = quot_reg[STAGES-1];
    assign out_ovf   = ovf_reg[STAGES-1];
    assign out_ctx   = ctx_reg[STAGES-1];

endmodule

// ===== src/motion_speed_table_check_unit.sv =====
`timescale 1ns / 1ps
// top level of the motion speed table check pipeline
//
//  channel   direction  tdata fields (lsb first)                          tuser / tlast
//  s_        in         axis_number 8, start_velocity 32, top_velocity 32,  none
//                       ramp_rate 40 (112 bits)
//  m_        out        status 3, start_speed 22, top_speed 23,            none
//                       accel_units 14, decel_units 14, zero pad 4 (80 bits)
//
// one beat in and one beat out per cycle while m_tready is high, through the
// front stage, two quantizing stages, the numerator stage, seven divider
// stages and the output register. aresetn clears only the valid bits, there
// is no clearing pass. each stage holds while its successor is full, so
// bubbles close up and the input keeps taking beats while a result waits.
module motion_speed_table_check_unit #(
    parameter int FRACTION_BITS = 8,
    parameter int AXIS_LIMIT    = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // axis_number, start_velocity, top_velocity, ramp_rate
    input  logic [111:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status, start_speed, top_speed, accel_units, decel_units, pad
    output logic [79:0]  m_tdata
);

    localparam int NUM_W = ((msc_pkg::TOP_W + msc_pkg::SCALE_W + FRACTION_BITS + 1 >
                             msc_pkg::RATE_W) ?
                            msc_pkg::TOP_W + msc_pkg::SCALE_W + FRACTION_BITS + 1 :
                            msc_pkg::RATE_W) + 1;

    // front stage
    logic                        f_valid, f_ready;
    msc_pkg::status_t            f_status;
    msc_pkg::range_idx_t         f_range;
    logic [msc_pkg::TOP_W-1:0]   f_top_pre;
    logic [msc_pkg::START_W-1:0] f_start;
    logic [msc_pkg::RATE_W-1:0]  f_rate;

    // quantizer
    logic                        q_valid, q_ready;
    msc_pkg::ctx_t               q_ctx;
    logic [msc_pkg::RATE_W-1:0]  q_rate;

    // numerator stage
    logic                        n_valid_reg, n_load;
    logic [NUM_W-1:0]            n_num_reg, n_num_next;
    logic [msc_pkg::RATE_W:0]    n_den_reg;
    msc_pkg::ctx_t               n_ctx_reg;
    logic [msc_pkg::TOP_W-1:0]   n_diff;
    logic                        d_ready;

    // divider
    logic                        d_valid;
    logic [msc_pkg::UNITS_W-1:0] d_quot;
    logic                        d_ovf;
    msc_pkg::ctx_t               d_ctx;

    // output register
    logic                        o_valid_reg, o_load;
    msc_pkg::status_t            o_status_reg, o_status_next;
    logic [msc_pkg::START_W-1:0] o_start_reg, o_start_next;
    logic [msc_pkg::TOP_W-1:0]   o_top_reg, o_top_next;
    logic [msc_pkg::UNITS_W-1:0] o_units_reg, o_units_next;
    logic                        ramp_bad;

    msc_front #(
        .FRACTION_BITS (FRACTION_BITS),
        .AXIS_LIMIT    (AXIS_LIMIT)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .axis_number    (s_tdata[7:0]),
        .start_velocity (s_tdata[39:8]),
        .top_velocity   (s_tdata[71:40]),
        .ramp_rate      (s_tdata[111:72]),
        .out_valid      (f_valid),
        .out_ready      (f_ready),
        .out_status     (f_status),
        .out_range      (f_range),
        .out_top_pre    (f_top_pre),
        .out_start      (f_start),
        .out_rate       (f_rate)
    );

    msc_quant u_quant (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (f_valid),
        .in_ready   (f_ready),
        .in_status  (f_status),
        .in_range   (f_range),
        .in_top_pre (f_top_pre),
        .in_start   (f_start),
        .in_rate    (f_rate),
        .out_valid  (q_valid),
        .out_ready  (q_ready),
        .out_ctx    (q_ctx),
        .out_rate   (q_rate)
    );

    // numerator 2 * 100 * 2^f * (top - start) + rate, denominator 2 * rate
    assign n_load  = !n_valid_reg || d_ready;
    assign q_ready = n_load;
    assign n_diff  = q_ctx.top - msc_pkg::TOP_W'(q_ctx.start);

    always_comb begin
        n_num_next = ((NUM_W'(n_diff) * NUM_W'(msc_pkg::RAMP_SCALE))
                      << (FRACTION_BITS + 1)) + NUM_W'(q_rate);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_valid_reg <= 1'b0;
        end else if (n_load) begin
            n_valid_reg <= q_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (n_load) begin
            n_num_reg <= n_num_next;
            n_den_reg <= {q_rate, 1'b0};
            n_ctx_reg <= q_ctx;
        end
    end

    msc_div #(
        .NUM_W (NUM_W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (n_valid_reg),
        .in_ready  (d_ready),
        .in_num    (n_num_reg),
        .in_den    (n_den_reg),
        .in_ctx    (n_ctx_reg),
        .out_valid (d_valid),
        .out_ready (o_load),
        .out_quot  (d_quot),
        .out_ovf   (d_ovf),
        .out_ctx   (d_ctx)
    );

    // ramp time limits and final status
    always_comb begin
        ramp_bad = d_ovf || (d_quot == '0) || (d_quot > msc_pkg::UNITS_MAX) ||
                   (d_quot < msc_pkg::range_min_units(d_ctx.range)) ||
                   (d_quot > msc_pkg::range_max_units(d_ctx.range));
        o_status_next = d_ctx.status;
        if (d_ctx.status == msc_pkg::ST_OK && ramp_bad) begin
            o_status_next = msc_pkg::ST_RAMP;
        end
        if (o_status_next == msc_pkg::ST_OK) begin
            o_start_next = d_ctx.start;
            o_top_next   = d_ctx.top;
            o_units_next = d_quot;
        end else begin
            o_start_next = '0;
            o_top_next   = '0;
            o_units_next = '0;
        end
    end

    assign o_load = !o_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg <= 1'b0;
        end else if (o_load) begin
            o_valid_reg <= d_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (o_load) begin
            o_status_reg <= o_status_next;
            o_start_reg  <= o_start_next;
            o_top_reg    <= o_top_next;
            o_units_reg  <= o_units_next;
        end
    end

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = {4'b0, o_units_reg, o_units_reg, o_top_reg, o_start_reg,
                       o_status_reg};

endmodule

// ===== src/msc_checker.sv =====
`timescale 1ns / 1ps
// port level checks for the speed table check unit, bound to the top level
module msc_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [79:0]  m_tdata
);

    // no result beat right after reset
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result beat valid right after reset");

    // a stalled result beat holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed");

    // failed checks carry zero speeds and units
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[2:0] != 3'd0) |-> (m_tdata[79:3] == '0))
        else $error("failed result carries nonzero fields");

    // accepted results keep decel equal to accel and inside limits
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[2:0] == 3'd0) |->
            (m_tdata[61:48] == m_tdata[75:62]) && (m_tdata[61:48] != '0) &&
            (m_tdata[61:48] <= 14'd10000) &&
            ({m_tdata[24:3], 1'b0} <= m_tdata[47:25]))
        else $error("accepted result outside its limits");

endmodule

bind motion_speed_table_check_unit msc_checker u_msc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
